/* src/necir_pkg.sv */
// Shared types, constants and helpers for the NEC infrared frame decoder.
package necir_pkg;

	localparam int FRAME_PAIRS_DEF = 33;

	localparam int DUR_W    = 16;
	localparam int CODE_W   = 32;
	localparam int RPT_W    = 16;
	localparam int TICK_W   = 2;
	localparam int CFG_IDX_W = 3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [CODE_W-1:0] CODE_MSB = 32'h8000_0000;
	localparam logic [CODE_W-1:0] CODE_ALL = 32'hFFFF_FFFF;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_LEN      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd7;

	localparam logic [DUR_W-1:0]  RST_TOLERANCE     = 16'd300;
	localparam logic [DUR_W-1:0]  RST_HEADER_MARK   = 16'd9000;
	localparam logic [DUR_W-1:0]  RST_HEADER_SPACE  = 16'd4500;
	localparam logic [DUR_W-1:0]  RST_REPEAT_SPACE  = 16'd2250;
	localparam logic [DUR_W-1:0]  RST_SHORT_LEN     = 16'd560;
	localparam logic [DUR_W-1:0]  RST_LONG_LEN      = 16'd1680;
	localparam logic [DUR_W-1:0]  RST_TICK_PERIOD   = 16'd10000;
	localparam logic [TICK_W-1:0] RST_TIMEOUT_TICKS = 2'd3;

	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic [DUR_W-1:0]  tolerance;
		logic [DUR_W-1:0]  header_mark;
		logic [DUR_W-1:0]  header_space;
		logic [DUR_W-1:0]  repeat_space;
		logic [DUR_W-1:0]  short_len;
		logic [DUR_W-1:0]  long_len;
		logic [DUR_W-1:0]  tick_period;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	typedef enum logic [1:0] {
		TOK_START = 2'd0,
		TOK_DUR   = 2'd1,
		TOK_END   = 2'd2
	} tok_kind_t;

	typedef struct packed {
		logic hdr_mark;
		logic hdr_space;
		logic rpt_space;
		logic short_len;
		logic long_len;
	} match_t;

	typedef struct packed {
		tok_kind_t kind;
		match_t    match;
	} token_t;

	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_FULL   = 2'd1,
		CLS_REPEAT = 2'd2
	} frame_class_t;

	typedef enum logic [1:0] {
		ST_INVALID = 2'd0,
		ST_CODE    = 2'd1,
		ST_REPEAT  = 2'd2
	} status_t;

	// |d - n| < tol, strict
	function automatic logic near_fn(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] n,
		input logic [DUR_W-1:0] tol);
		logic [DUR_W-1:0] ad;
		begin
			ad = (d >= n) ? (d - n) : (n - d);
			return ad < tol;
		end
	endfunction

endpackage

/* src/necir_in_if.sv */
// Input channel: edge events and timer ticks.
interface necir_in_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [necir_pkg::DUR_W-1:0]  edge_time;

	modport source (output valid, output req_type, output edge_time, input ready);
	modport sink (input valid, input req_type, input edge_time, output ready);
endinterface

/* src/necir_out_if.sv */
// Result channel: one decoded frame report per transfer.
interface necir_out_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [7:0]                   address;
	logic [7:0]                   address_inv;
	logic [7:0]                   command;
	logic [7:0]                   command_inv;
	logic [necir_pkg::RPT_W-1:0]  repeat_count;

	modport source (output valid, output status, output address, output address_inv,
		output command, output command_inv, output repeat_count, input ready);
	modport sink (input valid, input status, input address, input address_inv,
		input command, input command_inv, input repeat_count, output ready);
endinterface

/* src/necir_cfg_if.sv */
// Configuration write channel: register index and data.
interface necir_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [necir_pkg::CFG_IDX_W-1:0]  index;
	logic [necir_pkg::DUR_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/necir_front.sv */
// Front end: timestamps edges, counts ticks, classifies durations into tokens.
module necir_front (
	input  logic                  clk,
	input  logic                  arst_n,
	necir_in_if.sink              in_ch,
	input  necir_pkg::cfg_t       cfg,
	input  logic                  q_full,
	output logic                  push,
	output necir_pkg::token_t     tok
);

	logic                                idle_q;
	logic [necir_pkg::DUR_W-1:0]         last_edge_q;
	logic [necir_pkg::TICK_W-1:0]        tick_count_q;

	logic                                accept;
	logic [necir_pkg::DUR_W+1:0]         tick_us;
	logic [necir_pkg::DUR_W-1:0]         dur;
	logic [necir_pkg::TICK_W-1:0]        tick_inc;
	logic                                timeout;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	assign tick_us  = (necir_pkg::DUR_W+2)'(tick_count_q) * (necir_pkg::DUR_W+2)'(cfg.tick_period);
	assign dur      = tick_us[necir_pkg::DUR_W-1:0] + in_ch.edge_time - last_edge_q;
	assign tick_inc = tick_count_q + 1'b1;
	assign timeout  = (tick_inc == cfg.timeout_ticks);

	always_comb begin
		push                 = 1'b0;
		tok.kind             = necir_pkg::TOK_DUR;
		tok.match.hdr_mark   = necir_pkg::near_fn(dur, cfg.header_mark, cfg.tolerance);
		tok.match.hdr_space  = necir_pkg::near_fn(dur, cfg.header_space, cfg.tolerance);
		tok.match.rpt_space  = necir_pkg::near_fn(dur, cfg.repeat_space, cfg.tolerance);
		tok.match.short_len  = necir_pkg::near_fn(dur, cfg.short_len, cfg.tolerance);
		tok.match.long_len   = necir_pkg::near_fn(dur, cfg.long_len, cfg.tolerance);
		if (accept) begin
			if (in_ch.req_type == necir_pkg::REQ_EDGE) begin
				push     = 1'b1;
				tok.kind = idle_q ? necir_pkg::TOK_START : necir_pkg::TOK_DUR;
			end else if (!idle_q && timeout) begin
				push     = 1'b1;
				tok.kind = necir_pkg::TOK_END;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q       <= 1'b1;
			last_edge_q  <= '0;
			tick_count_q <= '0;
		end else if (accept) begin
			if (in_ch.req_type == necir_pkg::REQ_EDGE) begin
				idle_q       <= 1'b0;
				last_edge_q  <= in_ch.edge_time;
				tick_count_q <= '0;
			end else if (!idle_q) begin
				if (timeout) begin
					idle_q       <= 1'b1;
					tick_count_q <= '0;
				end else begin
					tick_count_q <= tick_inc;
				end
			end
		end
	end

endmodule

/* src/necir_fifo.sv */
// Short token queue between the front end and the frame decoder.
module necir_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  necir_pkg::token_t     push_tok,
	input  logic                  pop,
	output logic                  full,
	output logic                  valid,
	output necir_pkg::token_t     head
);

	necir_pkg::token_t                mem_q [necir_pkg::QDEPTH];
	logic [necir_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [necir_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [necir_pkg::QPTR_W:0]       count_q;

	assign full  = (count_q == (necir_pkg::QPTR_W+1)'(necir_pkg::QDEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/necir_back.sv */
// Back end: walks the duration sequence, assembles the code word, reports frames.
module necir_back #(
	parameter int FRAME_PAIRS = necir_pkg::FRAME_PAIRS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  necir_pkg::cfg_t       cfg,
	input  logic                  tok_valid,
	input  necir_pkg::token_t     tok,
	output logic                  pop,
	necir_out_if.source           out_ch
);

	localparam int BUF_LEN = 2 * FRAME_PAIRS;
	localparam int DI_W    = $clog2(BUF_LEN + 1);
	localparam int CW      = necir_pkg::CODE_W;
	// bit slots that the buffer reaches
	localparam logic [CW-1:0] K_LIM = ~(necir_pkg::CODE_ALL >> (FRAME_PAIRS - 1));

	logic [DI_W-1:0]                  di_q;
	necir_pkg::frame_class_t          cls_q;
	logic                             err_q;
	logic [CW-1:0]                    sw_q;
	logic [CW-1:0]                    code_q;
	logic [necir_pkg::RPT_W-1:0]      rt_q;

	logic                             out_valid_q;
	necir_pkg::status_t               res_status_q;
	logic [CW-1:0]                    res_code_q;
	logic [necir_pkg::RPT_W-1:0]      res_rt_q;

	// live duration
	logic [DI_W-1:0]                  k_live;
	logic [CW-1:0]                    mask_live;
	logic                             err_live;
	necir_pkg::frame_class_t          cls_live;
	logic [CW-1:0]                    sw_live;
	logic                             clr_live;

	// end-of-frame: missing durations count as zero
	logic                             z_hm, z_hs, z_rs, z_sh, z_lg;
	logic [DI_W-1:0]                  s_idx;
	logic [DI_W-1:0]                  s_odd;
	logic [DI_W-1:0]                  k_lo;
	logic                             any_left;
	logic                             has_even;
	logic [CW-1:0]                    mask_fl;
	logic                             err_fl;
	necir_pkg::frame_class_t          cls_fl;
	logic [CW-1:0]                    sw_fl;
	logic                             clr_fl;
	necir_pkg::status_t               status_fl;
	logic [CW-1:0]                    code_fl;
	logic [necir_pkg::RPT_W-1:0]      rt_fl;

	logic                             end_tok;
	logic                             slot_free;

	assign end_tok   = (tok.kind == necir_pkg::TOK_END);
	assign slot_free = !out_valid_q || out_ch.ready;
	assign pop       = tok_valid && (!end_tok || slot_free);

	// Live take of one duration at index di_q
	assign k_live    = (di_q >> 1) - DI_W'(1);
	assign mask_live = (int'(k_live) < CW) ? (necir_pkg::CODE_MSB >> k_live) : '0;

	always_comb begin
		err_live = err_q;
		cls_live = cls_q;
		sw_live  = sw_q;
		clr_live = 1'b0;
		if (di_q < DI_W'(BUF_LEN)) begin
			if (di_q == '0) begin
				if (!tok.match.hdr_mark) err_live = 1'b1;
			end else if (!err_q) begin
				if (di_q == DI_W'(1)) begin
					if (tok.match.hdr_space) begin
						cls_live = necir_pkg::CLS_FULL;
						clr_live = 1'b1;
					end else if (tok.match.rpt_space) begin
						cls_live = necir_pkg::CLS_REPEAT;
					end else begin
						err_live = 1'b1;
					end
				end else if (cls_q == necir_pkg::CLS_REPEAT) begin
					if (di_q == DI_W'(2) && !tok.match.short_len) err_live = 1'b1;
				end else if (cls_q == necir_pkg::CLS_FULL) begin
					if (!di_q[0]) begin
						if (!tok.match.short_len) err_live = 1'b1;
					end else if (tok.match.long_len) begin
						sw_live = sw_q | mask_live;
					end else if (tok.match.short_len) begin
						sw_live = sw_q & ~mask_live;
					end else begin
						err_live = 1'b1;
					end
				end
			end
		end
	end

	// A zero duration matches a nominal only when the nominal is below the tolerance.
	assign z_hm = necir_pkg::near_fn('0, cfg.header_mark, cfg.tolerance);
	assign z_hs = necir_pkg::near_fn('0, cfg.header_space, cfg.tolerance);
	assign z_rs = necir_pkg::near_fn('0, cfg.repeat_space, cfg.tolerance);
	assign z_sh = necir_pkg::near_fn('0, cfg.short_len, cfg.tolerance);
	assign z_lg = necir_pkg::near_fn('0, cfg.long_len, cfg.tolerance);

	// first data index still to be filled, and the first bit slot it reaches
	assign s_idx    = (di_q < DI_W'(2)) ? DI_W'(2) : di_q;
	assign any_left = (s_idx < DI_W'(BUF_LEN));
	assign has_even = (s_idx != DI_W'(BUF_LEN - 1));
	assign s_odd    = s_idx | DI_W'(1);
	assign k_lo     = (s_odd >> 1) - DI_W'(1);
	assign mask_fl  = (int'(k_lo) < CW) ? ((necir_pkg::CODE_ALL >> k_lo) & K_LIM) : '0;

	always_comb begin
		err_fl = err_q;
		cls_fl = cls_q;
		clr_fl = 1'b0;
		sw_fl  = sw_q;
		if (di_q == '0 && !z_hm) err_fl = 1'b1;
		if (di_q <= DI_W'(1) && !err_fl) begin
			if (z_hs) begin
				cls_fl = necir_pkg::CLS_FULL;
				clr_fl = 1'b1;
			end else if (z_rs) begin
				cls_fl = necir_pkg::CLS_REPEAT;
			end else begin
				err_fl = 1'b1;
			end
		end
		if (!err_fl && cls_fl == necir_pkg::CLS_REPEAT && s_idx == DI_W'(2) && !z_sh) begin
			err_fl = 1'b1;
		end
		if (cls_fl == necir_pkg::CLS_FULL && any_left) begin
			if (!err_fl && ((has_even && !z_sh) || (!z_lg && !z_sh))) err_fl = 1'b1;
			sw_fl = z_lg ? (sw_q | mask_fl) : (sw_q & ~mask_fl);
		end
	end

	always_comb begin
		code_fl = code_q;
		rt_fl   = clr_fl ? '0 : rt_q;
		if (err_fl || cls_fl == necir_pkg::CLS_NONE) begin
			status_fl = necir_pkg::ST_INVALID;
		end else if (cls_fl == necir_pkg::CLS_FULL) begin
			status_fl = necir_pkg::ST_CODE;
			code_fl   = sw_fl;
		end else begin
			status_fl = necir_pkg::ST_REPEAT;
			rt_fl     = rt_fl + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			di_q        <= '0;
			cls_q       <= necir_pkg::CLS_NONE;
			err_q       <= 1'b0;
			sw_q        <= '0;
			code_q      <= '0;
			rt_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && end_tok) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (tok.kind)
					necir_pkg::TOK_START: begin
						di_q  <= '0;
						cls_q <= necir_pkg::CLS_NONE;
						err_q <= 1'b0;
						sw_q  <= code_q;
					end
					necir_pkg::TOK_DUR: begin
						if (di_q < DI_W'(BUF_LEN)) di_q <= di_q + 1'b1;
						cls_q <= cls_live;
						err_q <= err_live;
						sw_q  <= sw_live;
						if (clr_live) rt_q <= '0;
					end
					necir_pkg::TOK_END: begin
						di_q        <= DI_W'(BUF_LEN);
						cls_q       <= cls_fl;
						err_q       <= err_fl;
						sw_q        <= sw_fl;
						code_q      <= code_fl;
						rt_q        <= rt_fl;
					end
					default: begin
						di_q <= di_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && end_tok) begin
			res_status_q <= status_fl;
			res_code_q   <= code_fl;
			res_rt_q     <= rt_fl;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = res_status_q;
	assign out_ch.address      = res_code_q[31:24];
	assign out_ch.address_inv  = res_code_q[23:16];
	assign out_ch.command      = res_code_q[15:8];
	assign out_ch.command_inv  = res_code_q[7:0];
	assign out_ch.repeat_count = res_rt_q;

endmodule

/* src/nec_ir_frame_decoder.sv */
// Top level of the NEC infrared frame decoder: registers, front end, queue, back end.
//
// in_ch carries timer events: req_type 0 is a captured edge with its timer value in
// edge_time (us), req_type 1 is a timer period tick. Every edge after the first of a
// frame closes a level whose duration is matched against the nominal lengths.
// After timeout_ticks ticks with no edge the frame ends and out_ch carries one report:
// status (0 invalid, 1 new code, 2 repeat), the stored code word split in four bytes,
// and the repeat count. Ticks that end no frame and edges produce no report.
// cfg_ch writes the eight timing registers (index 0..7); it is always ready and
// is meant to be written while no frame is in progress.
// Throughput: one input transfer per cycle while the queue is not full. The front end
// classifies each event in the cycle it arrives and queues a token; the back end retires
// one token a cycle unless an end-of-frame token meets a stalled report. With nothing
// queued ahead, a frame-ending tick writes the queue, then the back end loads the report.
// When out_ch stalls, the report waits in the output register; the back end keeps
// retiring edge tokens and stops only at the next end-of-frame token, and in_ch
// drops ready once the two-entry queue is full.
// Reset returns the registers to their defaults, clears the stored code and the
// repeat count, and leaves the decoder idle waiting for a first edge.
module nec_ir_frame_decoder #(
	parameter int FRAME_PAIRS = necir_pkg::FRAME_PAIRS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	necir_in_if.sink      in_ch,
	necir_out_if.source   out_ch,
	necir_cfg_if.sink     cfg_ch
);

	necir_pkg::cfg_t      cfg_q;
	logic                 q_full;
	logic                 q_push;
	necir_pkg::token_t    q_in_tok;
	logic                 q_valid;
	logic                 q_pop;
	necir_pkg::token_t    q_head;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance     <= necir_pkg::RST_TOLERANCE;
			cfg_q.header_mark   <= necir_pkg::RST_HEADER_MARK;
			cfg_q.header_space  <= necir_pkg::RST_HEADER_SPACE;
			cfg_q.repeat_space  <= necir_pkg::RST_REPEAT_SPACE;
			cfg_q.short_len     <= necir_pkg::RST_SHORT_LEN;
			cfg_q.long_len      <= necir_pkg::RST_LONG_LEN;
			cfg_q.tick_period   <= necir_pkg::RST_TICK_PERIOD;
			cfg_q.timeout_ticks <= necir_pkg::RST_TIMEOUT_TICKS;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			unique case (cfg_ch.index)
				necir_pkg::REG_TOLERANCE:     cfg_q.tolerance    <= cfg_ch.data;
				necir_pkg::REG_HEADER_MARK:   cfg_q.header_mark  <= cfg_ch.data;
				necir_pkg::REG_HEADER_SPACE:  cfg_q.header_space <= cfg_ch.data;
				necir_pkg::REG_REPEAT_SPACE:  cfg_q.repeat_space <= cfg_ch.data;
				necir_pkg::REG_SHORT_LEN:     cfg_q.short_len    <= cfg_ch.data;
				necir_pkg::REG_LONG_LEN:      cfg_q.long_len     <= cfg_ch.data;
				necir_pkg::REG_TICK_PERIOD:   cfg_q.tick_period  <= cfg_ch.data;
				necir_pkg::REG_TIMEOUT_TICKS:
					cfg_q.timeout_ticks <= cfg_ch.data[necir_pkg::TICK_W-1:0];
				default: cfg_q.tolerance <= cfg_q.tolerance;
			endcase
		end
	end

	necir_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (q_push),
		.tok    (q_in_tok)
	);

	necir_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tok (q_in_tok),
		.pop      (q_pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head)
	);

	necir_back #(
		.FRAME_PAIRS (FRAME_PAIRS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.tok_valid (q_valid),
		.tok       (q_head),
		.pop       (q_pop),
		.out_ch    (out_ch)
	);

	// queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("token queue overflow");

	// a pending report is never overwritten by the next frame end
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.kind == necir_pkg::TOK_END && out_ch.valid) |-> out_ch.ready)
		else $error("report overwritten while stalled");

	// only tokens that exist are retired
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.status == necir_pkg::ST_INVALID
			|| out_ch.status == necir_pkg::ST_CODE
			|| out_ch.status == necir_pkg::ST_REPEAT))
		else $error("undefined status code");

endmodule
